/* src/krs_pkg.sv */
// Shared types and constants for the k-nearest-neighbour radius selection block.
// No dependencies; every other file of the block but krs_ram imports this package.
package krs_pkg;

  localparam int COORD_W     = 16;
  localparam int NUM_COORDS  = 8;
  localparam int SQ_W        = 32;
  localparam int DIST_W      = 35;
  localparam int BEST_W      = DIST_W + 1;
  localparam int COUNT_W     = 9;
  localparam int INDEX_W     = 8;
  localparam int RANK_W      = 4;

  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(256);

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic scan_v;
    logic capture;
    logic clear;
    logic shift;
  } krs_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic busy;
    logic head_valid;
    logic head_last;
  } krs_stat_t;

endpackage

/* src/krs_if.sv */
// Handshake interfaces for the request, result and configuration channels.
// Depends on krs_pkg for the field widths.
interface krs_req_if
  import krs_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic                      command;
  logic [INDEX_W-1:0]        point_index;
  logic signed [COORD_W-1:0] coord0;
  logic signed [COORD_W-1:0] coord1;
  logic signed [COORD_W-1:0] coord2;
  logic signed [COORD_W-1:0] coord3;
  logic signed [COORD_W-1:0] coord4;
  logic signed [COORD_W-1:0] coord5;
  logic signed [COORD_W-1:0] coord6;
  logic signed [COORD_W-1:0] coord7;

  modport source (
    output valid, command, point_index,
           coord0, coord1, coord2, coord3, coord4, coord5, coord6, coord7,
    input  ready
  );
  modport sink (
    input  valid, command, point_index,
           coord0, coord1, coord2, coord3, coord4, coord5, coord6, coord7,
    output ready
  );
endinterface

interface krs_res_if
  import krs_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance;
  logic [RANK_W-1:0] rank;
  logic              last;

  modport source (output valid, distance, rank, last, input ready);
  modport sink   (input valid, distance, rank, last, output ready);
endinterface

interface krs_cfg_if
  import krs_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* src/krs_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module krs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/krs_ctrl.sv */
// Controller state machine: sequences loads, the store scan and result delivery.
// Depends on krs_pkg for the command and status structs.
module krs_ctrl
  import krs_pkg::*;
#(
  parameter int MAX_POINTS = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  logic                          req_command,
  input  logic [INDEX_W-1:0]            req_index,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [COUNT_W-1:0]            cfg_data,
  output logic                          res_valid,
  input  logic                          res_ready,
  output krs_cmd_t                      cmd,
  output logic [$clog2(MAX_POINTS)-1:0] addr,
  input  krs_stat_t                     stat
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = AW + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;
  localparam logic [2:0] S_LATCH = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0]         state, state_next;
  logic [INDEX_W-1:0] qidx, qidx_next;
  logic [CW-1:0]      cnt, cnt_next;
  logic [COUNT_W-1:0] point_count;
  logic [CW-1:0]      used;
  logic               idx_ok;

  assign cfg_ready = 1'b1;
  assign used   = (32'(point_count) > 32'(MAX_POINTS)) ? CW'(MAX_POINTS) : CW'(point_count);
  assign idx_ok = 32'(req_index) < 32'(MAX_POINTS);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      point_count <= COUNT_RESET;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        point_count <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    qidx <= qidx_next;
    cnt  <= cnt_next;
  end

  always_comb begin
    state_next = state;
    qidx_next  = qidx;
    cnt_next   = cnt;
    cmd        = '0;
    addr       = cnt[AW-1:0];
    req_ready  = 1'b0;
    res_valid  = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        addr      = AW'(req_index);
        if (req_valid && idx_ok) begin
          if (req_command == CMD_LOAD) begin
            cmd.wr_en = 1'b1;
          end else begin
            qidx_next  = req_index;
            state_next = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        cmd.rd_en  = 1'b1;
        addr       = AW'(qidx);
        state_next = S_LATCH;
      end
      S_LATCH: begin
        cmd.capture = 1'b1;
        cmd.clear   = 1'b1;
        cnt_next    = '0;
        state_next  = (used == '0) ? S_DRAIN : S_SCAN;
      end
      S_SCAN: begin
        cmd.rd_en  = 1'b1;
        cmd.scan_v = 32'(cnt) != 32'(qidx);
        cnt_next   = CW'(cnt + 1'b1);
        if (CW'(cnt + 1'b1) == used) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!stat.busy) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        res_valid = stat.head_valid;
        if (!stat.head_valid) begin
          state_next = S_IDLE;
        end else if (res_ready) begin
          cmd.shift = 1'b1;
          if (stat.head_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* src/krs_dp.sv */
// Datapath: point store, distance pipeline and the sorted list of nearest distances.
// Depends on krs_pkg and krs_ram.
module krs_dp
  import krs_pkg::*;
#(
  parameter int MAX_POINTS = 256,
  parameter int DIMENSIONS = 8,
  parameter int NEIGHBORS  = 10
) (
  input  logic                            clk,
  input  logic                            rst,
  input  krs_cmd_t                        cmd,
  input  logic [$clog2(MAX_POINTS)-1:0]   addr,
  input  logic [DIMENSIONS*COORD_W-1:0]   wdata,
  output krs_stat_t                       stat,
  output logic [DIST_W-1:0]               distance,
  output logic [RANK_W-1:0]               rank
);

  localparam int PW  = DIMENSIONS * COORD_W;
  localparam int NB1 = (NEIGHBORS > 1) ? 1 : 0;

  logic [PW-1:0]     rdata;
  logic [PW-1:0]     qpt;
  logic              s1_v, s2_v, s3_v;
  logic [SQ_W-1:0]   sq [DIMENSIONS];
  logic [DIST_W-1:0] sum, sum_comb;
  logic [BEST_W-1:0] cand;
  logic [BEST_W-1:0] best [NEIGHBORS];

  krs_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (addr),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else begin
      s1_v <= cmd.scan_v;
      s2_v <= s1_v;
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      qpt <= rdata;
    end
  end

  // One squared difference per dimension, each in its own multiplier.
  for (genvar gd = 0; gd < DIMENSIONS; gd++) begin : g_dim
    logic [COORD_W-1:0]          a, b;
    logic signed [COORD_W:0]     diff;
    logic signed [2*COORD_W+1:0] prod;
    assign a    = rdata[gd*COORD_W +: COORD_W];
    assign b    = qpt[gd*COORD_W +: COORD_W];
    assign diff = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
    assign prod = diff * diff;
    always_ff @(posedge clk) begin
      sq[gd] <= prod[SQ_W-1:0];
    end
  end

  always_comb begin
    sum_comb = '0;
    for (int d = 0; d < DIMENSIONS; d++) begin
      sum_comb = sum_comb + DIST_W'(sq[d]);
    end
  end

  always_ff @(posedge clk) begin
    sum <= sum_comb;
  end

  // Entries hold all ones when empty, which is larger than any distance, so an
  // insertion always lands before the empty tail.
  assign cand = {1'b0, sum};

  for (genvar gi = 0; gi < NEIGHBORS; gi++) begin : g_best
    logic [BEST_W-1:0] ins_val, shift_val;
    if (gi == 0) begin : g_head
      assign ins_val = (best[gi] <= cand) ? best[gi] : cand;
    end else begin : g_body
      assign ins_val = (best[gi] <= cand)   ? best[gi] :
                       (best[gi-1] <= cand) ? cand     : best[gi-1];
    end
    if (gi == NEIGHBORS - 1) begin : g_tail
      assign shift_val = '1;
    end else begin : g_mid
      assign shift_val = best[gi+1];
    end
    always_ff @(posedge clk) begin
      if (cmd.clear) begin
        best[gi] <= '1;
      end else if (s3_v) begin
        best[gi] <= ins_val;
      end else if (cmd.shift) begin
        best[gi] <= shift_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      rank <= '0;
    end else if (cmd.shift) begin
      rank <= RANK_W'(rank + 1'b1);
    end
  end

  assign distance        = best[0][DIST_W-1:0];
  assign stat.busy       = s1_v | s2_v | s3_v;
  assign stat.head_valid = ~best[0][BEST_W-1];
  assign stat.head_last  = (NEIGHBORS == 1) ? 1'b1 : best[NB1][BEST_W-1];

endmodule

/* src/knn_radius_selection.sv */
// Top level of the brute-force k-nearest-neighbour radius selection block.
// Depends on krs_pkg, krs_if, krs_ctrl and krs_dp.
//
//   Channel | Direction | Word carries
//   --------+-----------+-------------------------------------------------
//   cfg     | in        | data: new point_count
//   req     | in        | command, point_index, coord0 .. coord7
//   res     | out       | distance, rank, last
//
// A load returns no word. After its acceptance, a query first reads and then
// latches the query point, then reads the store once per point in use, with
// point_count capped at MAX_POINTS, and then drains the read, square, sum and
// insert stages before its first result word is offered. The single read port
// of the point store makes the scan read one point at a time. The results then
// leave one word per cycle while res is ready.
// Reset is synchronous; the point store is not cleared and holds nothing
// defined until loaded. A stalled result simply holds the block in delivery.
module knn_radius_selection
  import krs_pkg::*;
#(
  parameter int MAX_POINTS = 256,
  parameter int DIMENSIONS = 8,
  parameter int NEIGHBORS  = 10
) (
  input  logic  clk,
  input  logic  rst,
  krs_cfg_if.sink   cfg,
  krs_req_if.sink   req,
  krs_res_if.source res
);

  localparam int AW = $clog2(MAX_POINTS);

  krs_cmd_t                    cmd;
  krs_stat_t                   stat;
  logic [AW-1:0]               addr;
  logic [COORD_W-1:0]          coords [NUM_COORDS];
  logic [DIMENSIONS*COORD_W-1:0] wdata;

  // Only the first DIMENSIONS coordinates of a load word are stored.
  assign coords[0] = req.coord0;
  assign coords[1] = req.coord1;
  assign coords[2] = req.coord2;
  assign coords[3] = req.coord3;
  assign coords[4] = req.coord4;
  assign coords[5] = req.coord5;
  assign coords[6] = req.coord6;
  assign coords[7] = req.coord7;

  always_comb begin
    wdata = '0;
    for (int d = 0; d < DIMENSIONS; d++) begin
      wdata[d*COORD_W +: COORD_W] = coords[d];
    end
  end

  // The controller owns the handshakes and the point_count register.
  krs_ctrl #(
    .MAX_POINTS (MAX_POINTS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .req_command (req.command),
    .req_index   (req.point_index),
    .cfg_valid   (cfg.valid),
    .cfg_ready   (cfg.ready),
    .cfg_data    (cfg.data),
    .res_valid   (res.valid),
    .res_ready   (res.ready),
    .cmd         (cmd),
    .addr        (addr),
    .stat        (stat)
  );

  // The datapath holds the store, the distance pipeline and the sorted list,
  // whose head is the result word on offer.
  krs_dp #(
    .MAX_POINTS (MAX_POINTS),
    .DIMENSIONS (DIMENSIONS),
    .NEIGHBORS  (NEIGHBORS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .addr     (addr),
    .wdata    (wdata),
    .stat     (stat),
    .distance (res.distance),
    .rank     (res.rank)
  );

  assign res.last = stat.head_last;

endmodule
